// ----- sv/pn3d_pkg.sv -----
// shared types, constants and the gradient function for the 3d gradient noise core
// no dependencies
`default_nettype none

package pn3d_pkg;

	localparam int FRAC_BITS = 16;
	localparam int OUT_BITS  = 16;
	// signed datapath width: holds offsets, gradients, fade terms and lerp differences
	localparam int DW        = 26;
	localparam logic signed [DW-1:0] ONE_FX = DW'(1) <<< FRAC_BITS;

	localparam logic OP_EVAL  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic signed [DW-1:0] fx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RED,
		ST_RD,
		ST_LOOK,
		ST_MUL,
		ST_MWB,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MD_FADE,
		MD_LX,
		MD_LY,
		MD_LZ
	} mode_t;

	function automatic fx_t grad(input logic [3:0] h, input fx_t x, input fx_t y,
			input fx_t z);
		fx_t u;
		fx_t v;
		u = (h < 4'd8) ? x : y;
		if (h < 4'd4)
			v = y;
		else if (h == 4'd12 || h == 4'd14)
			v = x;
		else
			v = z;
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

endpackage

`default_nettype wire

// ----- sv/pn3d_mul.sv -----
// shared fixed-point multiplier: registered product, rounded by half up on the way out
// depends on pn3d_pkg
`default_nettype none

module pn3d_mul (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire pn3d_pkg::fx_t a,
	input  wire pn3d_pkg::fx_t b,
	output pn3d_pkg::fx_t      r
);

	localparam int PW = 2 * pn3d_pkg::DW;

	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] sum;
	logic signed [PW-1:0] shf;

	always_ff @(posedge clk) begin
		if (en)
			prod_s1 <= PW'(a) * PW'(b);
	end

	always_comb begin
		sum = prod_s1 + (PW'(1) <<< (pn3d_pkg::FRAC_BITS - 1));
		shf = sum >>> pn3d_pkg::FRAC_BITS;
		r   = shf[pn3d_pkg::DW-1:0];
	end

endmodule

`default_nettype wire

// ----- sv/perlin_noise_3d_core.sv -----
// 3d improved gradient noise core: sequencer, permutation memory and datapath
// depends on pn3d_pkg and pn3d_mul
`default_nettype none

// Each request either writes one permutation entry (operation 1, no result) or
// evaluates noise at an unsigned Q8.16 point (operation 0, one Q0.16 result).
// After reset the table is filled with its identity contents, one entry per cycle,
// so the block takes no request until it is filled. A request is held off while
// one is in work. A write first reduces its index modulo TABLE_SIZE, then writes.
// An evaluate runs everything through one multiplier and one table read port: it
// takes the request, runs the fades of the three axes, 8 corners of 3 chained lookups
// (each index first reduced modulo TABLE_SIZE) and 7 lerps, then loads the output
// register. A new request is taken only after the output register has been loaded.
// A finished result waits in the output register while the next request is taken.
module perlin_noise_3d_core #(
	parameter int TABLE_SIZE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [23:0] x_coord,
	input  wire logic [23:0] y_coord,
	input  wire logic [23:0] z_coord,
	input  wire logic [7:0]  table_index,
	input  wire logic [7:0]  table_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      noise_value
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int AW = (IW > 9) ? IW : 9;
	localparam int FB = pn3d_pkg::FRAC_BITS;
	localparam int DW = pn3d_pkg::DW;

	pn3d_pkg::state_t state_q, state_d;
	pn3d_pkg::mode_t  mode_q;

	logic [7:0]    mem [TABLE_SIZE];
	logic [7:0]    rdata_q;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [7:0]    mem_wd;

	logic [IW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic          addr_big;
	logic          wr_q;
	logic [7:0]    wval_q;
	logic [23:0]   x_q, y_q, z_q;
	logic [1:0]    dim_q;
	logic [1:0]    fk_q;
	logic [2:0]    corner_q;
	logic [1:0]    lv_q;

	pn3d_pkg::fx_t op_a_q, op_b_q, mul_r;
	pn3d_pkg::fx_t t3_q, s0_q, s1_q, s2_q;
	pn3d_pkg::fx_t ga_q, xa_q, ya_q, la_q;
	pn3d_pkg::fx_t res, tcur, tnext, qv, fv, gv, acc;
	pn3d_pkg::fx_t ox, oy, oz;
	logic [16:0]   half;
	logic [15:0]   out_q;
	logic          out_valid_q;
	logic          out_load;

	pn3d_mul u_mul (
		.clk (clk),
		.en  (state_q == pn3d_pkg::ST_MUL),
		.a   (op_a_q),
		.b   (op_b_q),
		.r   (mul_r)
	);

	assign addr_big = {1'b0, addr_q} >= (AW+1)'(TABLE_SIZE);

	function automatic pn3d_pkg::fx_t frac_of(input logic [23:0] c);
		return DW'(c[FB-1:0]);
	endfunction

	function automatic logic [AW-1:0] corner_addr(input logic [7:0] xi, input logic bit0);
		return AW'(xi) + AW'(bit0);
	endfunction

	// datapath combinational terms
	always_comb begin
		unique case (dim_q)
			2'd0:    tcur = frac_of(x_q);
			2'd1:    tcur = frac_of(y_q);
			default: tcur = frac_of(z_q);
		endcase
		tnext = (dim_q == 2'd0) ? frac_of(y_q) : frac_of(z_q);
		res = la_q + mul_r;
		qv  = DW'(10) * pn3d_pkg::ONE_FX - DW'(15) * tcur + mul_r;
		if (qv < 0)
			qv = '0;
		fv = mul_r;
		if (fv < 0)
			fv = '0;
		if (fv > pn3d_pkg::ONE_FX)
			fv = pn3d_pkg::ONE_FX;
		ox = frac_of(x_q) - (corner_q[0] ? pn3d_pkg::ONE_FX : '0);
		oy = frac_of(y_q) - (corner_q[1] ? pn3d_pkg::ONE_FX : '0);
		oz = frac_of(z_q) - (corner_q[2] ? pn3d_pkg::ONE_FX : '0);
		gv = pn3d_pkg::grad(rdata_q[3:0], ox, oy, oz);
		acc = res + pn3d_pkg::ONE_FX;
		if (acc < 0)
			acc = '0;
		if (acc > (pn3d_pkg::ONE_FX <<< 1))
			acc = pn3d_pkg::ONE_FX <<< 1;
		half = 17'((acc + DW'(1)) >>> 1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pn3d_pkg::ST_CLEAR: begin
				if (clr_q == IW'(TABLE_SIZE - 1))
					state_d = pn3d_pkg::ST_IDLE;
			end
			pn3d_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = (operation == pn3d_pkg::OP_WRITE) ? pn3d_pkg::ST_RED
						: pn3d_pkg::ST_MUL;
			end
			pn3d_pkg::ST_RED: begin
				if (!addr_big)
					state_d = wr_q ? pn3d_pkg::ST_IDLE : pn3d_pkg::ST_RD;
			end
			pn3d_pkg::ST_RD: state_d = pn3d_pkg::ST_LOOK;
			pn3d_pkg::ST_LOOK: begin
				if (lv_q != 2'd2 || !corner_q[0])
					state_d = pn3d_pkg::ST_RED;
				else
					state_d = pn3d_pkg::ST_MUL;
			end
			pn3d_pkg::ST_MUL: state_d = pn3d_pkg::ST_MWB;
			pn3d_pkg::ST_MWB: begin
				unique case (mode_q)
					pn3d_pkg::MD_FADE:
						state_d = (fk_q == 2'd3 && dim_q == 2'd2) ? pn3d_pkg::ST_RED
							: pn3d_pkg::ST_MUL;
					pn3d_pkg::MD_LX:
						state_d = corner_q[1] ? pn3d_pkg::ST_MUL : pn3d_pkg::ST_RED;
					pn3d_pkg::MD_LY:
						state_d = corner_q[2] ? pn3d_pkg::ST_MUL : pn3d_pkg::ST_RED;
					default: state_d = pn3d_pkg::ST_OUT;
				endcase
			end
			pn3d_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall)
					state_d = pn3d_pkg::ST_IDLE;
			end
			default: state_d = pn3d_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall = (state_q != pn3d_pkg::ST_IDLE);
		out_load = (state_q == pn3d_pkg::ST_OUT) && (!out_valid_q || !out_stall);
		mem_we   = (state_q == pn3d_pkg::ST_CLEAR)
			|| (state_q == pn3d_pkg::ST_RED && wr_q && !addr_big);
		mem_wa   = (state_q == pn3d_pkg::ST_CLEAR) ? clr_q : addr_q[IW-1:0];
		mem_wd   = (state_q == pn3d_pkg::ST_CLEAR) ? 8'(clr_q) : wval_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (state_q == pn3d_pkg::ST_RD)
			rdata_q <= mem[addr_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pn3d_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pn3d_pkg::ST_CLEAR)
				clr_q <= clr_q + IW'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= (half > 17'd65535) ? 16'hFFFF : half[15:0];
		unique case (state_q)
			pn3d_pkg::ST_IDLE: begin
				wr_q   <= (operation == pn3d_pkg::OP_WRITE);
				wval_q <= table_value;
				addr_q <= AW'(table_index);
				x_q    <= x_coord;
				y_q    <= y_coord;
				z_q    <= z_coord;
				dim_q  <= 2'd0;
				fk_q   <= 2'd0;
				mode_q <= pn3d_pkg::MD_FADE;
				op_a_q <= DW'(x_coord[FB-1:0]);
				op_b_q <= DW'(x_coord[FB-1:0]);
			end
			pn3d_pkg::ST_RED: begin
				if (addr_big)
					addr_q <= addr_q - AW'(TABLE_SIZE);
			end
			pn3d_pkg::ST_LOOK: begin
				if (lv_q == 2'd0) begin
					addr_q <= AW'(rdata_q) + AW'(y_q[23:16]) + AW'(corner_q[1]);
					lv_q   <= 2'd1;
				end else if (lv_q == 2'd1) begin
					addr_q <= AW'(rdata_q) + AW'(z_q[23:16]) + AW'(corner_q[2]);
					lv_q   <= 2'd2;
				end else if (!corner_q[0]) begin
					ga_q     <= gv;
					corner_q <= corner_q + 3'd1;
					lv_q     <= 2'd0;
					addr_q   <= corner_addr(x_q[23:16], 1'b1);
				end else begin
					op_a_q <= s0_q;
					op_b_q <= gv - ga_q;
					la_q   <= ga_q;
					mode_q <= pn3d_pkg::MD_LX;
				end
			end
			pn3d_pkg::ST_MWB: begin
				unique case (mode_q)
					pn3d_pkg::MD_FADE: begin
						fk_q <= fk_q + 2'd1;
						unique case (fk_q)
							2'd0: begin
								op_a_q <= mul_r;
								op_b_q <= tcur;
							end
							2'd1: begin
								t3_q   <= mul_r;
								op_a_q <= DW'(6) * tcur;
								op_b_q <= tcur;
							end
							2'd2: begin
								op_a_q <= t3_q;
								op_b_q <= qv;
							end
							default: begin
								unique case (dim_q)
									2'd0:    s0_q <= fv;
									2'd1:    s1_q <= fv;
									default: s2_q <= fv;
								endcase
								dim_q  <= dim_q + 2'd1;
								op_a_q <= tnext;
								op_b_q <= tnext;
								// end of each axis's fade: set up corner zero, used once the last fade is done
								corner_q <= 3'd0;
								lv_q     <= 2'd0;
								addr_q   <= corner_addr(x_q[23:16], 1'b0);
							end
						endcase
					end
					pn3d_pkg::MD_LX: begin
						if (!corner_q[1]) begin
							xa_q     <= res;
							corner_q <= corner_q + 3'd1;
							lv_q     <= 2'd0;
							addr_q   <= corner_addr(x_q[23:16], 1'b0);
						end else begin
							op_a_q <= s1_q;
							op_b_q <= res - xa_q;
							la_q   <= xa_q;
							mode_q <= pn3d_pkg::MD_LY;
						end
					end
					pn3d_pkg::MD_LY: begin
						if (!corner_q[2]) begin
							ya_q     <= res;
							corner_q <= corner_q + 3'd1;
							lv_q     <= 2'd0;
							addr_q   <= corner_addr(x_q[23:16], 1'b0);
						end else begin
							op_a_q <= s2_q;
							op_b_q <= res - ya_q;
							la_q   <= ya_q;
							mode_q <= pn3d_pkg::MD_LZ;
						end
					end
					// la_q and the product stay put so res holds the noise in ST_OUT
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign noise_value = out_q;

endmodule

`default_nettype wire

// ----- bench/tb_perlin_noise_3d_core.sv -----
// self-checking bench for perlin_noise_3d_core: table writes and noise evaluations
// depends on pn3d_pkg and the core; expected noise is computed by a local fixed-point predictor
`default_nettype none

module tb_perlin_noise_3d_core;

	localparam longint ONE = 64'sd1 << 16;
	localparam int WATCHDOG_LIMIT = 20000;

	class noise_scoreboard;
		bit [7:0] perm [256];
		bit [15:0] pending [$];
		int errors;

		function new();
			for (int i = 0; i < 256; i++) perm[i] = i[7:0];
			errors = 0;
		endfunction

		function longint rmul(longint a, longint b);
			return (a * b + (ONE >>> 1)) >>> 16;
		endfunction

		function longint smooth(longint t);
			longint t2, t3, q, f;
			t2 = rmul(t, t);
			t3 = rmul(t2, t);
			q = 10 * ONE - 15 * t + rmul(6 * t, t);
			if (q < 0) q = 0;
			f = rmul(t3, q);
			if (f < 0) f = 0;
			if (f > ONE) f = ONE;
			return f;
		endfunction

		function longint mix(longint t, longint a, longint b);
			return a + rmul(t, b - a);
		endfunction

		function longint slope(bit [3:0] h, longint x, longint y, longint z);
			longint u, v;
			u = (h < 8) ? x : y;
			if (h < 4) v = y;
			else if (h == 12 || h == 14) v = x;
			else v = z;
			return (h[0] ? -u : u) + (h[1] ? -v : v);
		endfunction

		function bit [7:0] hash(bit [7:0] i, bit [7:0] j, bit [7:0] k);
			bit [7:0] a, b;
			a = perm[i] + j;
			b = perm[a] + k;
			return perm[b];
		endfunction

		function bit [15:0] noise_at(bit [23:0] cx, bit [23:0] cy, bit [23:0] cz);
			bit [7:0] ix [3];
			bit [7:0] nx [3];
			bit [7:0] ci, cj, ck, hv;
			longint f [3];
			longint s [3];
			longint g [8];
			longint x1, x2, y1, y2, n, acc, val;
			ix[0] = cx[23:16]; ix[1] = cy[23:16]; ix[2] = cz[23:16];
			f[0] = cx[15:0]; f[1] = cy[15:0]; f[2] = cz[15:0];
			for (int d = 0; d < 3; d++) begin
				nx[d] = ix[d] + 8'd1;
				s[d] = smooth(f[d]);
			end
			// corner c: bit0 x, bit1 y, bit2 z
			for (int c = 0; c < 8; c++) begin
				ci = c[0] ? nx[0] : ix[0];
				cj = c[1] ? nx[1] : ix[1];
				ck = c[2] ? nx[2] : ix[2];
				hv = hash(ci, cj, ck);
				g[c] = slope(hv[3:0], f[0] - (c[0] ? ONE : 0),
					f[1] - (c[1] ? ONE : 0), f[2] - (c[2] ? ONE : 0));
			end
			x1 = mix(s[0], g[0], g[1]);
			x2 = mix(s[0], g[2], g[3]);
			y1 = mix(s[1], x1, x2);
			x1 = mix(s[0], g[4], g[5]);
			x2 = mix(s[0], g[6], g[7]);
			y2 = mix(s[1], x1, x2);
			n = mix(s[2], y1, y2);
			acc = n + ONE;
			if (acc < 0) acc = 0;
			if (acc > 2 * ONE) acc = 2 * ONE;
			val = ((acc << 16) + ONE) >>> 17;
			if (val > 65535) val = 65535;
			return val[15:0];
		endfunction

		function void note_request(bit op, bit [23:0] cx, bit [23:0] cy, bit [23:0] cz,
				bit [7:0] idx, bit [7:0] value);
			if (op == pn3d_pkg::OP_WRITE) perm[idx] = value;
			else pending = {pending, noise_at(cx, cy, cz)};
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(bit [15:0] got);
			bit [15:0] want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected noise_value %0d", got));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				report_mismatch($sformatf("noise_value got %0d want %0d", got, want));
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, operation;
	logic [23:0] x_coord, y_coord, z_coord;
	logic [7:0] table_index, table_value;
	logic out_valid, out_stall;
	logic [15:0] noise_value;

	noise_scoreboard board;
	int idle_cycles = 0;
	bit stall_long;

	perlin_noise_3d_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.table_index(table_index), .table_value(table_value),
		.out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// send one request, holding valid while it is stalled; valid stays up until a pause
	task automatic send_request(bit op, bit [23:0] cx, bit [23:0] cy, bit [23:0] cz,
			bit [7:0] idx, bit [7:0] value);
		in_valid <= 1'b1;
		operation <= op;
		x_coord <= cx;
		y_coord <= cy;
		z_coord <= cz;
		table_index <= idx;
		table_value <= value;
		do @(posedge clk); while (in_stall);
		board.note_request(op, cx, cy, cz, idx, value);
	endtask

	// drop valid and let the sender sit idle
	task automatic pause(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic bit [23:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 24'($urandom());
			1: return {$urandom_range(0, 3) == 0 ? 8'hff : 8'($urandom_range(0, 3)),
				16'($urandom())};
			2: return {8'($urandom()), $urandom_range(0, 1) ? 16'hffff : 16'h0000};
			default: return {8'($urandom()), 16'($urandom_range(0, 8)) << 12};
		endcase
	endfunction

	// receiver stalls in alternating calm and busy stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_long <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_long <= ~stall_long;
			out_stall <= stall_long ? ($urandom_range(0, 3) != 0) : 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) board.check_result(noise_value);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int burst, tail;
		bit [23:0] c [3];
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = pn3d_pkg::OP_EVAL;
		x_coord = '0; y_coord = '0; z_coord = '0;
		table_index = '0; table_value = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, lattice points, wraps and table edges
		send_request(pn3d_pkg::OP_EVAL, 24'h0, 24'h0, 24'h0, 8'h00, 8'h00);
		send_request(pn3d_pkg::OP_EVAL, 24'hffffff, 24'hffffff, 24'hffffff, 8'hff, 8'hff);
		send_request(pn3d_pkg::OP_EVAL, 24'h008000, 24'h008000, 24'h008000, 8'h00, 8'h00);
		send_request(pn3d_pkg::OP_EVAL, 24'hff0000, 24'h00ffff, 24'h7f8000, 8'h00, 8'h00);
		send_request(pn3d_pkg::OP_EVAL, 24'h010000, 24'h020000, 24'hff0000, 8'h00, 8'h00);
		send_request(pn3d_pkg::OP_WRITE, 24'hffffff, 24'hffffff, 24'hffffff, 8'hff, 8'h00);
		send_request(pn3d_pkg::OP_WRITE, 24'h0, 24'h0, 24'h0, 8'h00, 8'hff);
		send_request(pn3d_pkg::OP_WRITE, 24'h0, 24'h0, 24'h0, 8'h01, 8'haa);
		send_request(pn3d_pkg::OP_WRITE, 24'h0, 24'h0, 24'h0, 8'h80, 8'h55);
		send_request(pn3d_pkg::OP_EVAL, 24'hffffff, 24'h000000, 24'hff8000, 8'h00, 8'h00);
		send_request(pn3d_pkg::OP_EVAL, 24'h00ffff, 24'hff0001, 24'h000001, 8'h00, 8'h00);
		send_request(pn3d_pkg::OP_EVAL, 24'h804000, 24'h01c000, 24'hfe2000, 8'h00, 8'h00);
		for (int h = 0; h < 16; h++)
			send_request(pn3d_pkg::OP_WRITE, 24'h0, 24'h0, 24'h0, 8'(h), 8'(h * 17));
		send_request(pn3d_pkg::OP_EVAL, 24'h003000, 24'h00a000, 24'h00e000, 8'h00, 8'h00);

		// random: mostly evaluations, table rewrites sprinkled in, bursty sender
		for (int n = 0; n < 1500; n += burst) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++) begin
				for (int d = 0; d < 3; d++) c[d] = rand_coord();
				send_request($urandom_range(0, 4) == 0 ? pn3d_pkg::OP_WRITE
					: pn3d_pkg::OP_EVAL,
					c[0], c[1], c[2], 8'($urandom()), 8'($urandom()));
			end
			if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 40));
		end
		pause(1);

		while (board.pending.size() != 0) @(posedge clk);
		tail = 0;
		while (tail < 300) begin
			@(posedge clk);
			tail++;
		end
		if (board.pending.size() != 0) board.report_mismatch("expected results left over");
		if (board.errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

`default_nettype wire
